// File: hdl/spd_pkg.sv
`timescale 1ns / 1ps
package spd_pkg;

    localparam int PKT_BYTES   = 19;
    localparam int CRC_BYTES   = 16;
    localparam int STORE_BYTES = 18;
    localparam int POS_W       = 5;

    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t WAIT_POS = pos_t'(PKT_BYTES);
    localparam pos_t LAST_POS = pos_t'(PKT_BYTES - 1);

    localparam logic [1:0] CFG_CRC_INITIAL    = 2'd0;
    localparam logic [1:0] CFG_CRC_POLYNOMIAL = 2'd1;
    localparam logic [1:0] CFG_HEADER_FIRST   = 2'd2;
    localparam logic [1:0] CFG_HEADER_SECOND  = 2'd3;

    localparam logic [15:0] CRC_INITIAL_RST    = 16'h2F61;
    localparam logic [15:0] CRC_POLYNOMIAL_RST = 16'h8005;
    localparam logic [7:0]  HEADER_FIRST_RST   = 8'hD3;
    localparam logic [7:0]  HEADER_SECOND_RST  = 8'h91;

    localparam logic [1:0] STATUS_NORMAL   = 2'd0;
    localparam logic [1:0] STATUS_UNLINK   = 2'd1;
    localparam logic [1:0] STATUS_BATTERY  = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

    localparam logic [7:0] STATUS_NORMAL_CODE  = 8'h00;
    localparam logic [7:0] STATUS_UNLINK_CODE  = 8'h40;
    localparam logic [7:0] STATUS_BATTERY_CODE = 8'h80;
    localparam logic [7:0] EXTERNAL_CODE       = 8'h02;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } byte_item_t;

    typedef struct packed {
        logic        header_ok;
        logic [1:0]  status_kind;
        logic [7:0]  status_raw;
        logic        external_present;
        logic [15:0] firmware_word;
        logic [7:0]  battery_percent;
        logic [15:0] device_id;
        logic [15:0] internal_temp_tenths;
        logic [15:0] external_temp_tenths;
        logic [15:0] humidity_tenths;
        logic        crc_ok;
        logic [7:0]  trailer_byte;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        pos_t       pos;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_stat_t;

    typedef struct packed {
        logic [15:0] crc_initial;
        logic [15:0] crc_polynomial;
        logic [7:0]  header_first;
        logic [7:0]  header_second;
    } cfg_t;

    // Fold one byte into a right-shifting CRC-16, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ poly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hdl/sensor_packet_decoder_unit.sv
`timescale 1ns / 1ps
// result_valid is registered; it rises after the back pops the 19th byte of a packet.
// Throughput: one byte per cycle while the queue has room; the front tracks byte position,
// a two-entry command queue parts it from the back, which folds bytes 0..15 into the CRC.
// A byte stalls only when the queue is full, i.e. a final byte waits on a held result.
// Reset: asynchronous, active low; position waits for a start, CRC clears, config
// registers take their default values, no result pending.
module sensor_packet_decoder_unit
    import spd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_item_t  byte_data,
    input  logic        byte_valid,
    output logic        byte_ready,
    output result_t     result_data,
    output logic        result_valid,
    input  logic        result_ready,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_write_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       byte_accept;
    logic       cmd_push;
    logic       cmd_pop;
    cmd_t       cmd_wr;
    cmd_t       cmd_rd;
    fifo_stat_t fifo_stat;

    // Config registers: write-only; user must write only while block is idle; unchecked.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CRC_INITIAL:    cfg_next.crc_initial    = cfg_write_data;
                CFG_CRC_POLYNOMIAL: cfg_next.crc_polynomial = cfg_write_data;
                CFG_HEADER_FIRST:   cfg_next.header_first   = cfg_write_data[7:0];
                CFG_HEADER_SECOND:  cfg_next.header_second  = cfg_write_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_initial    <= CRC_INITIAL_RST;
            cfg_reg.crc_polynomial <= CRC_POLYNOMIAL_RST;
            cfg_reg.header_first   <= HEADER_FIRST_RST;
            cfg_reg.header_second  <= HEADER_SECOND_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Accept a byte whenever the queue has room; ignored bytes are dropped in the front.
    assign byte_ready  = !fifo_stat.full;
    assign byte_accept = byte_valid && byte_ready;

    // Front: restart on a start flag, tag each live byte with its position.
    spd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (byte_data),
        .accept   (byte_accept),
        .cmd_push (cmd_push),
        .cmd_wr   (cmd_wr)
    );

    // Queue: decouple position tracking from CRC and result formation.
    spd_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wr    (cmd_wr),
        .pop   (cmd_pop),
        .rd    (cmd_rd),
        .stat  (fifo_stat)
    );

    // Back: advance the CRC, capture bytes, build the result on the last byte.
    spd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_rd       (cmd_rd),
        .fifo_stat    (fifo_stat),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // A push into a full queue would lose a transaction.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.full |-> !cmd_push)
        else $error("command pushed into full queue");

    // The back never pops an empty queue.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> fifo_stat.valid)
        else $error("command popped from empty queue");

    // Only positions inside a packet reach the queue.
    a_push_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd_wr.pos < WAIT_POS))
        else $error("out-of-packet byte queued");

    // A new result only follows the pop of a final byte.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd_pop && (cmd_rd.pos == LAST_POS)))
        else $error("result raised without a final byte");

endmodule

// File: hdl/spd_front.sv
`timescale 1ns / 1ps
module spd_front
    import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_item_t item,
    input  logic       accept,
    output logic       cmd_push,
    output cmd_t       cmd_wr
);

    pos_t pos_reg;
    pos_t pos_next;
    pos_t eff_pos;

    always_comb
    begin
        eff_pos  = item.packet_start ? '0 : pos_reg;
        cmd_push = accept && (eff_pos < WAIT_POS);
        cmd_wr.data_byte = item.data_byte;
        cmd_wr.pos       = eff_pos;
        pos_next = pos_reg;
        if (cmd_push)
            pos_next = eff_pos + pos_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= WAIT_POS;
        else
            pos_reg <= pos_next;
    end

endmodule

// File: hdl/spd_cmd_fifo.sv
`timescale 1ns / 1ps
module spd_cmd_fifo
    import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cmd_t       wr,
    input  logic       pop,
    output cmd_t       rd,
    output fifo_stat_t stat
);

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    always_comb
    begin
        stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
        stat.valid = (count_reg != '0);
        do_push    = push && !stat.full;
        do_pop     = pop && stat.valid;
        rd         = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + FIFO_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - FIFO_CNT_W'(1);
        end
    end

endmodule

// File: hdl/spd_back.sv
`timescale 1ns / 1ps
module spd_back
    import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  cmd_t       cmd_rd,
    input  fifo_stat_t fifo_stat,
    output logic       cmd_pop,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result_data
);

    logic [7:0]  store_reg [STORE_BYTES];
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     out_next;
    logic        is_last;
    logic [7:0]  s3;

    always_comb
    begin
        is_last = (cmd_rd.pos == LAST_POS);
        // Hold a final byte only while a finished result is still waiting.
        cmd_pop = fifo_stat.valid && (!is_last || !out_valid_reg || result_ready);

        crc_next = crc_reg;
        if (cmd_pop && (cmd_rd.pos < pos_t'(CRC_BYTES)))
            crc_next = crc_feed((cmd_rd.pos == '0) ? cfg.crc_initial : crc_reg,
                                cmd_rd.data_byte, cfg.crc_polynomial);

        s3 = store_reg[3];
        if (s3 == STATUS_NORMAL_CODE)
            out_next.status_kind = STATUS_NORMAL;
        else if (s3 == STATUS_UNLINK_CODE)
            out_next.status_kind = STATUS_UNLINK;
        else if (s3 == STATUS_BATTERY_CODE)
            out_next.status_kind = STATUS_BATTERY;
        else
            out_next.status_kind = STATUS_UNKNOWN;
        out_next.header_ok = (store_reg[0] == cfg.header_first) &&
                             (store_reg[1] == cfg.header_second);
        out_next.status_raw           = s3;
        out_next.external_present     = (store_reg[4] == EXTERNAL_CODE);
        out_next.firmware_word        = {store_reg[5], store_reg[6]};
        out_next.battery_percent      = store_reg[7];
        out_next.device_id            = {store_reg[8], store_reg[9]};
        out_next.internal_temp_tenths = {store_reg[11], store_reg[10]};
        out_next.external_temp_tenths = {store_reg[13], store_reg[12]};
        out_next.humidity_tenths      = {store_reg[15], store_reg[14]};
        out_next.crc_ok               = (crc_reg == {store_reg[17], store_reg[16]});
        out_next.trailer_byte         = cmd_rd.data_byte;

        out_valid_next = out_valid_reg && !result_ready;
        if (cmd_pop && is_last)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            if (cmd_pop && (cmd_rd.pos == pos_t'(i)))
                store_reg[i] <= cmd_rd.data_byte;
        end
        if (cmd_pop && is_last)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

// File: bench/spd_decode_checker.sv
`timescale 1ns / 1ps
module spd_decode_checker
    import spd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_item_t  byte_data,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  result_t     result_data,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_write_data,
    output int          mismatch_count,
    output int          pending,
    output int          decoded_count,
    output int          crc_match_count
);

    cfg_t        shadow_cfg;
    pos_t        next_pos;
    logic [15:0] running_crc;
    logic [7:0]  frame_bytes [PKT_BYTES];
    result_t     decoded_q [$];
    int          fails;
    int          decoded;
    int          crc_hits;

    // Bit-serial form: feed data LSB first, XOR the polynomial on feedback.
    function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc,
                                                    input logic [7:0] b,
                                                    input logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ poly;
        end
        return c;
    endfunction

    task automatic apply_write(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_CRC_INITIAL:    shadow_cfg.crc_initial    = val;
            CFG_CRC_POLYNOMIAL: shadow_cfg.crc_polynomial = val;
            CFG_HEADER_FIRST:   shadow_cfg.header_first   = val[7:0];
            CFG_HEADER_SECOND:  shadow_cfg.header_second  = val[7:0];
            default: ;
        endcase
    endtask

    // Advance the decoder state by one byte; queue a decoded packet on byte 18.
    task automatic absorb_byte(input byte_item_t it);
        result_t r;
        if (it.packet_start)
        begin
            next_pos    = '0;
            running_crc = shadow_cfg.crc_initial;
        end
        if (next_pos >= PKT_BYTES)
            return;
        frame_bytes[next_pos] = it.data_byte;
        if (next_pos < CRC_BYTES)
            running_crc = crc16_fold_byte(running_crc, it.data_byte, shadow_cfg.crc_polynomial);
        next_pos = next_pos + 1'b1;
        if (next_pos != WAIT_POS)
            return;

        r.header_ok = (frame_bytes[0] == shadow_cfg.header_first) &&
                      (frame_bytes[1] == shadow_cfg.header_second);
        case (frame_bytes[3])
            STATUS_NORMAL_CODE:  r.status_kind = STATUS_NORMAL;
            STATUS_UNLINK_CODE:  r.status_kind = STATUS_UNLINK;
            STATUS_BATTERY_CODE: r.status_kind = STATUS_BATTERY;
            default:             r.status_kind = STATUS_UNKNOWN;
        endcase
        r.status_raw           = frame_bytes[3];
        r.external_present     = (frame_bytes[4] == EXTERNAL_CODE);
        r.firmware_word        = {frame_bytes[5], frame_bytes[6]};
        r.battery_percent      = frame_bytes[7];
        r.device_id            = {frame_bytes[8], frame_bytes[9]};
        r.internal_temp_tenths = {frame_bytes[11], frame_bytes[10]};
        r.external_temp_tenths = {frame_bytes[13], frame_bytes[12]};
        r.humidity_tenths      = {frame_bytes[15], frame_bytes[14]};
        r.crc_ok               = (running_crc == {frame_bytes[17], frame_bytes[16]});
        r.trailer_byte         = frame_bytes[18];
        decoded_q.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            fails++;
        end
    endtask

    task automatic match_result(input result_t got);
        result_t want;
        if (decoded_q.size() == 0)
        begin
            $error("result transaction with no decoded packet outstanding");
            fails++;
            return;
        end
        want = decoded_q.pop_front();
        decoded++;
        if (want.crc_ok)
            crc_hits++;
        check_field("header_ok",            16'(want.header_ok),       16'(got.header_ok));
        check_field("status_kind",          16'(want.status_kind),     16'(got.status_kind));
        check_field("status_raw",           16'(want.status_raw),      16'(got.status_raw));
        check_field("external_present",     16'(want.external_present),
                    16'(got.external_present));
        check_field("firmware_word",        want.firmware_word,        got.firmware_word);
        check_field("battery_percent",      16'(want.battery_percent),
                    16'(got.battery_percent));
        check_field("device_id",            want.device_id,            got.device_id);
        check_field("internal_temp_tenths", want.internal_temp_tenths,
                    got.internal_temp_tenths);
        check_field("external_temp_tenths", want.external_temp_tenths,
                    got.external_temp_tenths);
        check_field("humidity_tenths",      want.humidity_tenths,      got.humidity_tenths);
        check_field("crc_ok",               16'(want.crc_ok),          16'(got.crc_ok));
        check_field("trailer_byte",         16'(want.trailer_byte),    16'(got.trailer_byte));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg.crc_initial    = CRC_INITIAL_RST;
            shadow_cfg.crc_polynomial = CRC_POLYNOMIAL_RST;
            shadow_cfg.header_first   = HEADER_FIRST_RST;
            shadow_cfg.header_second  = HEADER_SECOND_RST;
            next_pos    = WAIT_POS;
            running_crc = '0;
            foreach (frame_bytes[i])
                frame_bytes[i] = '0;
            decoded_q.delete();
            fails    = 0;
            decoded  = 0;
            crc_hits = 0;
        end
        else
        begin
            if (cfg_write_en)
                apply_write(cfg_index, cfg_write_data);
            if (byte_valid && byte_ready)
                absorb_byte(byte_data);
            if (result_valid && result_ready)
                match_result(result_data);
        end
        // Publish after the edge so readers never race the update.
        mismatch_count  <= fails;
        pending         <= decoded_q.size();
        decoded_count   <= decoded;
        crc_match_count <= crc_hits;
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import spd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 165;   // bytes of whole packets per register setting

    logic        clk;
    logic        rst_n;
    byte_item_t  byte_data;
    logic        byte_valid;
    logic        byte_ready;
    result_t     result_data;
    logic        result_valid;
    logic        result_ready;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_write_data;

    int mismatch_count;
    int pending;
    int decoded_count;
    int crc_match_count;

    // Register values currently in the block, mirrored so frames can be built
    // with a matching header and a valid CRC.
    logic [15:0] seed_now;
    logic [15:0] poly_now;
    logic [7:0]  hdr0_now;
    logic [7:0]  hdr1_now;

    logic [7:0] frame [PKT_BYTES];
    int         burst_left;
    int         bytes_sent;
    int         packet_bytes;
    int         cycles;
    bit         hold_request;

    sensor_packet_decoder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_data      (byte_data),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .result_data    (result_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data)
    );

    spd_decode_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_data       (byte_data),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .result_data     (result_data),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_write_data  (cfg_write_data),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .decoded_count   (decoded_count),
        .crc_match_count (crc_match_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // CRC of frame bytes 0..15 under the current register values; used only to
    // seal frames so that a good share of packets carry a matching checksum.
    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        c = seed_now;
        for (int i = 0; i < CRC_BYTES; i++)
        begin
            c = c ^ {8'h00, frame[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ poly_now) : (c >> 1);
        end
        return c;
    endfunction

    // Offer one byte transaction and hold it until accepted. The sender runs in
    // bursts: when a burst is used up, first drop valid for a random gap, which may be none.
    task automatic push_byte(input logic [7:0] b, input logic s);
        byte_item_t item;
        int         gap;
        item.data_byte    = b;
        item.packet_start = s;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Now and then a long burst, so some stretches see no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
        end
        byte_data  <= item;
        byte_valid <= 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Send the first n bytes of the frame; byte 0 carries the start flag.
    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
            push_byte(frame[i], i == 0);
    endtask

    // Fill the frame with random content, steered toward the interesting cases:
    // matching header, each status class, the external-sensor code, good CRC.
    task automatic fill_frame();
        logic [15:0] crc;
        int          flavor;
        flavor = $urandom_range(0, 9);
        foreach (frame[i])
            frame[i] = (flavor == 0) ? 8'h00 : (flavor == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
        begin
            frame[0] = hdr0_now;
            frame[1] = hdr1_now;
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            // Only one header byte right.
            if ($urandom_range(0, 1) == 1)
                frame[0] = hdr0_now;
            else
                frame[1] = hdr1_now;
        end
        case ($urandom_range(0, 4))
            0: frame[3] = STATUS_NORMAL_CODE;
            1: frame[3] = STATUS_UNLINK_CODE;
            2: frame[3] = STATUS_BATTERY_CODE;
            default: ;
        endcase
        if ($urandom_range(0, 1) == 1)
            frame[4] = EXTERNAL_CODE;
        crc = frame_crc();
        if ($urandom_range(0, 3) != 0)
            {frame[17], frame[16]} = crc;
        else if ($urandom_range(0, 1) == 1)
            {frame[17], frame[16]} = crc ^ (16'h0001 << $urandom_range(0, 15));
    endtask

    // One random unit of traffic: mostly whole packets, the rest broken ones
    // and noise.
    task automatic run_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            fill_frame();
            send_frame(PKT_BYTES);
            packet_bytes += PKT_BYTES;
            // Trailing bytes past byte 18 must be dropped by the block.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (pick < 82)
        begin
            // Truncated packet: the next start abandons it.
            fill_frame();
            send_frame($urandom_range(1, PKT_BYTES - 1));
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Hold the sender until every decoded packet has come out, then give the
    // CRC back end time to finish bytes that produce no result.
    task automatic settle();
        byte_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_write_en   <= 1'b1;
        cfg_index      <= idx;
        cfg_write_data <= val;
        @(posedge clk);
    endtask

    // Write all four registers back to back; call only while the block is idle.
    task automatic set_config(input logic [15:0] seed, input logic [15:0] poly,
                              input logic [7:0] h0, input logic [7:0] h1);
        write_reg(CFG_CRC_INITIAL,    seed);
        write_reg(CFG_CRC_POLYNOMIAL, poly);
        write_reg(CFG_HEADER_FIRST,   {8'h00, h0});
        write_reg(CFG_HEADER_SECOND,  {8'h00, h1});
        cfg_write_en <= 1'b0;
        seed_now = seed;
        poly_now = poly;
        hdr0_now = h0;
        hdr1_now = h1;
    endtask

    // Receiver: switch among stall patterns at intervals set by rx_tick. On request, hold
    // ready low for a long stretch so results back up and the input stalls.
    initial
    begin
        int rx_mode;
        int rx_tick;
        int hold_left;
        rx_mode = 0;
        rx_tick = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                hold_left = $urandom_range(200, 300);
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            else
            begin
                if (rx_tick % 64 == 0)
                    rx_mode = $urandom_range(0, 3);
                rx_tick++;
                case (rx_mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= (rx_tick % 4 == 0);
                    default: result_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int ph;
        int target;

        rst_n          <= 1'b0;
        byte_valid     <= 1'b0;
        byte_data      <= '0;
        cfg_write_en   <= 1'b0;
        cfg_index      <= CFG_CRC_INITIAL;
        cfg_write_data <= '0;
        seed_now     = CRC_INITIAL_RST;
        poly_now     = CRC_POLYNOMIAL_RST;
        hdr0_now     = HEADER_FIRST_RST;
        hdr1_now     = HEADER_SECOND_RST;
        burst_left   = 0;
        bytes_sent   = 0;
        packet_bytes = 0;
        hold_request = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a stray byte while waiting for a start is ignored.
        push_byte(8'hFF, 1'b0);
        // A partial packet, then a new start mid-packet that drops it.
        push_byte(hdr0_now, 1'b1);
        push_byte(hdr1_now, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(STATUS_UNLINK_CODE, 1'b0);
        // A clean packet under reset values: header match, normal status,
        // external sensor present, payload at both byte extremes, good CRC.
        frame[0] = hdr0_now;
        frame[1] = hdr1_now;
        frame[2] = 8'hFF;
        frame[3] = STATUS_NORMAL_CODE;
        frame[4] = EXTERNAL_CODE;
        for (int i = 5; i < CRC_BYTES; i++)
            frame[i] = (i % 2 == 1) ? 8'hFF : 8'h00;
        {frame[17], frame[16]} = frame_crc();
        frame[18] = 8'hFF;
        send_frame(PKT_BYTES);
        // Bytes after byte 18 without a start are dropped.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        settle();

        // Random phases, one register setting each, extremes included.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1: set_config(16'h0000, 16'h0000, 8'h00, 8'h00);
                2: set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                3, 4: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                5: set_config(CRC_INITIAL_RST, CRC_POLYNOMIAL_RST,
                              HEADER_FIRST_RST, HEADER_SECOND_RST);
                default: ;
            endcase
            // Stall the receiver for a long stretch while the sender keeps going.
            if (ph == 1 || ph == 4)
                hold_request = 1'b1;
            target = packet_bytes + PHASE_BYTES;
            while (packet_bytes < target)
                run_unit();
            settle();
        end

        $display("summary: %0d byte transactions over %0d register settings, %0d packets decoded",
                 bytes_sent, PHASES, decoded_count);
        $display("summary: %0d packets had a matching CRC; receiver held off twice",
                 crc_match_count);
        if (mismatch_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: sensor_packet_decoder_unit.f
hdl/spd_pkg.sv
hdl/spd_front.sv
hdl/spd_cmd_fifo.sv
hdl/spd_back.sv
hdl/sensor_packet_decoder_unit.sv
bench/spd_decode_checker.sv
bench/tb.sv
